// ===== rtl/core/cid_pkg.sv =====
// Shared types and codes for the ceiling integer divider.
package cid_pkg;

  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  localparam logic KIND_UNSIGNED = 1'b0;
  localparam logic KIND_SIGNED   = 1'b1;

  // Side information that travels with each beat through the divide stages.
  typedef struct packed {
    logic sgn;       // signed operands
    logic neg;       // true quotient is negative
    logic div_zero;  // divisor was zero
  } cid_ctl_t;

endpackage

// ===== rtl/core/cid_pre.sv =====
// Operand prep stage: magnitudes, quotient sign and zero-divisor flag.
module cid_pre import cid_pkg::*; #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_vld,
  input  logic         kind,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         vld,
  output cid_ctl_t     ctl,
  output logic [W-1:0] mag_a,
  output logic [W-1:0] mag_b
);

  logic         sgn;
  logic [W-1:0] mag_a_next;
  logic [W-1:0] mag_b_next;

  assign sgn = (kind == KIND_SIGNED);

  always_comb begin
    mag_a_next = (sgn && dividend[W-1]) ? (~dividend + 1'b1) : dividend;
    mag_b_next = (sgn && divisor[W-1])  ? (~divisor + 1'b1)  : divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    mag_a        <= mag_a_next;
    mag_b        <= mag_b_next;
    ctl.sgn      <= sgn;
    ctl.neg      <= sgn && (dividend[W-1] ^ divisor[W-1]);
    ctl.div_zero <= (divisor == '0);
  end

endmodule

// ===== rtl/core/cid_stage.sv =====
// One restoring-division stage: retires one quotient bit per beat.
module cid_stage import cid_pkg::*; #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         vld_in,
  input  cid_ctl_t     ctl_in,
  input  logic [W-1:0] rem_in,
  input  logic [W-1:0] dq_in,   // dividend bits still to shift in, quotient bits below
  input  logic [W-1:0] dvs_in,
  output logic         vld,
  output cid_ctl_t     ctl,
  output logic [W-1:0] rem,
  output logic [W-1:0] dq,
  output logic [W-1:0] dvs
);

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         ge;
  logic [W-1:0] rem_next;

  always_comb begin
    trial    = {rem_in, dq_in[W-1]};
    diff     = trial - {1'b0, dvs_in};
    ge       = ~diff[W];
    rem_next = ge ? diff[W-1:0] : trial[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    ctl <= ctl_in;
    rem <= rem_next;
    dq  <= {dq_in[W-2:0], ge};
    dvs <= dvs_in;
  end

endmodule

// ===== rtl/core/cid_post.sv =====
// Result stage: ceiling round, sign restore, saturation and status.
module cid_post import cid_pkg::*; #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                vld_in,
  input  cid_ctl_t            ctl_in,
  input  logic [W-1:0]        rem_in,
  input  logic [W-1:0]        quo_in,
  output logic                done,
  output logic [W-1:0]        quotient,
  output logic [STATUS_W-1:0] status
);

  localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};

  logic [W-1:0]        q_up;
  logic [W-1:0]        quotient_next;
  logic [STATUS_W-1:0] status_next;

  // positive quotients round up on a nonzero remainder; negative ones are
  // already rounded up by truncation
  assign q_up = (|rem_in) ? (quo_in + 1'b1) : quo_in;

  always_comb begin
    quotient_next = q_up;
    status_next   = ST_OK;
    if (ctl_in.div_zero) begin
      quotient_next = '0;
      status_next   = ST_DIV_ZERO;
    end else if (ctl_in.sgn && ctl_in.neg) begin
      quotient_next = ~quo_in + 1'b1;
    end else if (ctl_in.sgn && q_up[W-1]) begin
      quotient_next = MAXPOS;
      status_next   = ST_OVERFLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    quotient <= quotient_next;
    status   <= status_next;
  end

endmodule

// ===== rtl/core/ceiling_integer_divider_core.sv =====
// Top level of the pipelined ceiling integer divider.
//
//   channel   ports                           handshake
//   --------  ------------------------------  ---------------------------
//   command   kind, dividend, divisor         start & !busy
//   result    quotient, status                done, one cycle, no stall
//
// One beat may enter every cycle; busy is never raised.
// The pipeline has one prep stage, one restoring-division
// stage per quotient bit and one rounding stage.
// rst (synchronous) clears only the valid bits; payload flows unreset.
// The receiver cannot stall, so the pipeline always advances.
module ceiling_integer_divider_core import cid_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  kind,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic [STATUS_W-1:0]   status
);

  localparam int W   = DATA_WIDTH;
  localparam int LAT = DATA_WIDTH + 2;
  localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};

  logic         vld_p [0:W];
  cid_ctl_t     ctl_p [0:W];
  logic [W-1:0] rem_p [0:W];
  logic [W-1:0] dq_p  [0:W];
  logic [W-1:0] dvs_p [0:W];

  assign busy = 1'b0;

  cid_pre #(.W(W)) u_pre (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (start && !busy),
    .kind     (kind),
    .dividend (dividend),
    .divisor  (divisor),
    .vld      (vld_p[0]),
    .ctl      (ctl_p[0]),
    .mag_a    (dq_p[0]),
    .mag_b    (dvs_p[0])
  );

  assign rem_p[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_stage
    cid_stage #(.W(W)) u_stage (
      .clk    (clk),
      .rst    (rst),
      .vld_in (vld_p[i]),
      .ctl_in (ctl_p[i]),
      .rem_in (rem_p[i]),
      .dq_in  (dq_p[i]),
      .dvs_in (dvs_p[i]),
      .vld    (vld_p[i+1]),
      .ctl    (ctl_p[i+1]),
      .rem    (rem_p[i+1]),
      .dq     (dq_p[i+1]),
      .dvs    (dvs_p[i+1])
    );
  end

  cid_post #(.W(W)) u_post (
    .clk      (clk),
    .rst      (rst),
    .vld_in   (vld_p[W]),
    .ctl_in   (ctl_p[W]),
    .rem_in   (rem_p[W]),
    .quo_in   (dq_p[W]),
    .done     (done),
    .quotient (quotient),
    .status   (status)
  );

  // every result beat comes from an earlier accepted command
  a_done_has_cmd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result beat without matching command");

  a_zero_quotient: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_DIV_ZERO) |-> (quotient == '0))
    else $error("divide by zero with nonzero quotient");

  a_zero_divisor: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_DIV_ZERO) |-> ($past(divisor, LAT) == '0))
    else $error("divide-by-zero status on nonzero divisor");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OVERFLOW) |->
      (quotient == MAXPOS && $past(kind, LAT) == KIND_SIGNED))
    else $error("overflow status without signed saturation");

endmodule
